[hw/rtl/mppt_ic_pkg.sv]
package mppt_ic_pkg;

   // Sample and register widths.
   localparam int SAMPLE_W    = 16;
   localparam int FRAC_BITS   = 16;
   localparam int CD_W        = 24;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = CD_W;

   // Datapath widths. The shared multiplier takes a signed A operand wide
   // enough for the conductance band or a signed difference, and a signed
   // B operand wide enough for a product of two samples.
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int MA_W   = ((CD_W > DIFF_W) ? CD_W : DIFF_W) + 1;
   localparam int MB_W   = 2 * SAMPLE_W + 1;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = 2 * SAMPLE_W + 2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_DB  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLTAGE_DB  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_CONDUCT_DB  = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT_MAX = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT_MIN = CSR_INDEX_W'(5);

   typedef enum logic [1:0] {
      MOVE_HOLD     = 2'd0,
      MOVE_INCREASE = 2'd1,
      MOVE_DECREASE = 2'd2
   } move_type;

   // Micro-operations carried out by the datapath.
   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_LOAD,
      UOP_ZERO_TEST,
      UOP_MUL_DIV,
      UOP_MUL_IDV,
      UOP_MUL_W,
      UOP_MUL_Q,
      UOP_COMPARE,
      UOP_SMALL,
      UOP_UPDATE
   } uop_type;

   // Jump conditions of the sequencer.
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_GOTO,
      COND_NO_REQ,
      COND_SMALL,
      COND_ZERO_V
   } cond_type;

   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] ST_IDLE       = STEP_W'(0);
   localparam logic [STEP_W-1:0] ST_TEST_SMALL = STEP_W'(1);
   localparam logic [STEP_W-1:0] ST_TEST_ZERO  = STEP_W'(2);
   localparam logic [STEP_W-1:0] ST_MUL_DIV    = STEP_W'(3);
   localparam logic [STEP_W-1:0] ST_MUL_IDV    = STEP_W'(4);
   localparam logic [STEP_W-1:0] ST_MUL_W      = STEP_W'(5);
   localparam logic [STEP_W-1:0] ST_MUL_Q      = STEP_W'(6);
   localparam logic [STEP_W-1:0] ST_COMPARE    = STEP_W'(7);
   localparam logic [STEP_W-1:0] ST_SMALL      = STEP_W'(8);
   localparam logic [STEP_W-1:0] ST_UPDATE     = STEP_W'(9);

   typedef struct packed {
      uop_type                uop;
      cond_type               cond;
      logic [STEP_W-1:0]      target;
      logic                   wait_out;
   } ucode_word_type;

   // The microprogram. A word whose condition holds jumps to its target,
   // otherwise the step counter advances by one.
   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      w = '{uop: UOP_NOP, cond: COND_GOTO, target: ST_IDLE, wait_out: 1'b0};
      unique case (step)
         ST_IDLE:       w = '{UOP_LOAD,      COND_NO_REQ, ST_IDLE,     1'b0};
         ST_TEST_SMALL: w = '{UOP_NOP,       COND_SMALL,  ST_SMALL,    1'b0};
         ST_TEST_ZERO:  w = '{UOP_ZERO_TEST, COND_ZERO_V, ST_UPDATE,   1'b0};
         ST_MUL_DIV:    w = '{UOP_MUL_DIV,   COND_NEXT,   ST_IDLE,     1'b0};
         ST_MUL_IDV:    w = '{UOP_MUL_IDV,   COND_NEXT,   ST_IDLE,     1'b0};
         ST_MUL_W:      w = '{UOP_MUL_W,     COND_NEXT,   ST_IDLE,     1'b0};
         ST_MUL_Q:      w = '{UOP_MUL_Q,     COND_NEXT,   ST_IDLE,     1'b0};
         ST_COMPARE:    w = '{UOP_COMPARE,   COND_GOTO,   ST_UPDATE,   1'b0};
         ST_SMALL:      w = '{UOP_SMALL,     COND_NEXT,   ST_IDLE,     1'b0};
         ST_UPDATE:     w = '{UOP_UPDATE,    COND_GOTO,   ST_IDLE,     1'b1};
         default:       w = '{UOP_NOP,       COND_GOTO,   ST_IDLE,     1'b0};
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/mppt_incremental_conductance.sv]
// Incremental-conductance maximum power point tracker. Each request beat
// carries one panel sample (voltage in mV, current in mA); each response
// beat returns the new voltage setpoint, the perturbation that was decided
// (hold, increase or decrease, before clamping) and a flag that is set when
// the conductance test was due but the sample voltage was zero. Control is
// a ten-word microprogram held in a constant table, which steps a small
// datapath built around one shared signed multiplier. A sample whose
// voltage change lies inside the voltage deadband, or whose voltage is
// zero, goes from acceptance to the result register through a test of the
// voltage change, a test for zero voltage or a decision on the current
// change, and the setpoint update. Every other sample goes through both
// tests, four passes through the multiplier, each registered before its
// result is used, a compare and the update. The sequencer returns to its
// idle step on the update cycle. A finished response waits in its output
// register, so the next sample is taken as soon as the sequencer is back
// at its idle step; the sequencer holds its final step only while an
// earlier response is still waiting to be taken. Configuration writes are
// always accepted and should only be issued while no sample is in flight.
module mppt_incremental_conductance
   import mppt_ic_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_panel_voltage,
   input  logic [SAMPLE_W-1:0]    req_panel_current,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_W-1:0]    rsp_voltage_setpoint,
   output logic [1:0]             rsp_move,
   output logic                   rsp_zero_voltage,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [SAMPLE_W-1:0] step_size_ff;
   logic [SAMPLE_W-1:0] current_db_ff;
   logic [SAMPLE_W-1:0] voltage_db_ff;
   logic [CD_W-1:0]     conduct_db_ff;
   logic [SAMPLE_W-1:0] setpoint_max_ff;
   logic [SAMPLE_W-1:0] setpoint_min_ff;

   // Tracker state.
   logic [SAMPLE_W-1:0] last_v_ff;
   logic [SAMPLE_W-1:0] last_i_ff;
   logic [SAMPLE_W-1:0] setpoint_ff, setpoint_in;

   // Sequencer.
   logic [STEP_W-1:0]   step_ff, step_in;
   ucode_word_type      word;
   logic                exec;
   logic                jump;

   // Datapath registers.
   logic [SAMPLE_W-1:0]       v_ff;
   logic [SAMPLE_W-1:0]       i_ff;
   logic signed [DIFF_W-1:0]  dv_ff;
   logic signed [DIFF_W-1:0]  di_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   move_type                  mv_ff, mv_in;
   logic                      zv_ff, zv_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_setpoint_ff;
   move_type            rsp_move_ff;
   logic                rsp_zv_ff;
   logic                out_busy;
   logic                load_beat;
   logic                update_now;

   // Combinational helpers.
   logic [DIFF_W-1:0]        abs_dv;
   logic [SAMPLE_W-1:0]      adv;
   logic                     small_dv;
   logic                     v_zero;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic                     acc_neg;
   logic [ACC_W-1:0]         acc_mag;
   logic [PROD_W-1:0]        q_band;
   logic signed [DIFF_W:0]   di_x;
   logic signed [DIFF_W:0]   cb_x;
   logic signed [SAMPLE_W+1:0] sp_sum;
   logic signed [SAMPLE_W+1:0] sp_clamp;
   logic signed [SAMPLE_W+1:0] sp_max_x;
   logic signed [SAMPLE_W+1:0] sp_min_x;
   logic signed [SAMPLE_W+1:0] sp_top_x;

   assign word       = ucode_rom(step_ff);
   assign out_busy   = rsp_valid_ff && !rsp_ready;
   assign exec       = !(word.wait_out && out_busy);
   assign req_ready  = (word.uop == UOP_LOAD);
   assign load_beat  = req_valid && req_ready;
   assign update_now = (word.uop == UOP_UPDATE) && exec;
   assign csr_ready  = 1'b1;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_voltage_setpoint = rsp_setpoint_ff;
   assign rsp_move             = rsp_move_ff;
   assign rsp_zero_voltage     = rsp_zv_ff;

   // Magnitude of the voltage change; it always fits the sample width.
   assign abs_dv   = dv_ff[DIFF_W-1] ? DIFF_W'(-dv_ff) : DIFF_W'(dv_ff);
   assign adv      = abs_dv[SAMPLE_W-1:0];
   assign small_dv = (dv_ff == '0) || (adv < voltage_db_ff);
   assign v_zero   = (v_ff == '0);

   // Sequencer next step.
   always_comb begin
      unique case (word.cond)
         COND_NEXT:   jump = 1'b0;
         COND_GOTO:   jump = 1'b1;
         COND_NO_REQ: jump = !req_valid;
         COND_SMALL:  jump = small_dv;
         COND_ZERO_V: jump = v_zero;
         default:     jump = 1'b1;
      endcase
      if (!exec) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (word.uop)
         UOP_MUL_DIV: begin
            mul_a = MA_W'(di_ff);
            mul_b = $signed(MB_W'(v_ff));
         end
         UOP_MUL_IDV: begin
            mul_a = MA_W'(dv_ff);
            mul_b = $signed(MB_W'(i_ff));
         end
         UOP_MUL_W: begin
            mul_a = $signed(MA_W'(adv));
            mul_b = $signed(MB_W'(v_ff));
         end
         UOP_MUL_Q: begin
            mul_a = $signed(MA_W'(conduct_db_ff));
            mul_b = $signed(MB_W'(prod_ff[2*SAMPLE_W-1:0]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // The conductance sum s = dI*V + I*dV, sign-corrected for dV, against the
   // band floor(cd * |dV| * V / 2^F).
   assign acc_neg = acc_ff[ACC_W-1];
   assign acc_mag = acc_neg ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign q_band  = $unsigned(prod_ff) >> FRAC_BITS;

   assign di_x = (DIFF_W + 1)'(di_ff);
   assign cb_x = $signed((DIFF_W + 1)'(current_db_ff));

   // Setpoint step and clamp: max first, then min, then the sample range.
   assign sp_max_x = $signed((SAMPLE_W + 2)'(setpoint_max_ff));
   assign sp_min_x = $signed((SAMPLE_W + 2)'(setpoint_min_ff));
   assign sp_top_x = $signed((SAMPLE_W + 2)'({SAMPLE_W{1'b1}}));

   always_comb begin
      case (mv_ff)
         MOVE_INCREASE: sp_sum = $signed((SAMPLE_W + 2)'(setpoint_ff))
                                 + $signed((SAMPLE_W + 2)'(step_size_ff));
         MOVE_DECREASE: sp_sum = $signed((SAMPLE_W + 2)'(setpoint_ff))
                                 - $signed((SAMPLE_W + 2)'(step_size_ff));
         default:       sp_sum = $signed((SAMPLE_W + 2)'(setpoint_ff));
      endcase
      if (sp_sum > sp_max_x) begin
         sp_clamp = sp_max_x;
      end else if (sp_sum < sp_min_x) begin
         sp_clamp = sp_min_x;
      end else begin
         sp_clamp = sp_sum;
      end
      if (sp_clamp < 0) begin
         setpoint_in = '0;
      end else if (sp_clamp > sp_top_x) begin
         setpoint_in = {SAMPLE_W{1'b1}};
      end else begin
         setpoint_in = sp_clamp[SAMPLE_W-1:0];
      end
   end

   // Datapath next values.
   always_comb begin
      acc_in  = acc_ff;
      prod_in = prod_ff;
      mv_in   = mv_ff;
      zv_in   = zv_ff;
      case (word.uop)
         UOP_ZERO_TEST: begin
            mv_in = MOVE_HOLD;
            zv_in = v_zero;
         end
         UOP_MUL_DIV: begin
            prod_in = mul_p;
         end
         UOP_MUL_IDV: begin
            acc_in  = ACC_W'(prod_ff);
            prod_in = mul_p;
         end
         UOP_MUL_W: begin
            acc_in  = acc_ff + ACC_W'(prod_ff);
            prod_in = mul_p;
         end
         UOP_MUL_Q: begin
            prod_in = mul_p;
            if (dv_ff[DIFF_W-1]) begin
               acc_in = -acc_ff;
            end
         end
         UOP_COMPARE: begin
            if (PROD_W'(acc_mag) > q_band) begin
               mv_in = acc_neg ? MOVE_DECREASE : MOVE_INCREASE;
            end else begin
               mv_in = MOVE_HOLD;
            end
         end
         UOP_SMALL: begin
            zv_in = 1'b0;
            if (di_x > cb_x) begin
               mv_in = MOVE_INCREASE;
            end else if (di_x < -cb_x) begin
               mv_in = MOVE_DECREASE;
            end else begin
               mv_in = MOVE_HOLD;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (update_now) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         step_size_ff    <= SAMPLE_W'(10);
         current_db_ff   <= SAMPLE_W'(5);
         voltage_db_ff   <= SAMPLE_W'(5);
         conduct_db_ff   <= CD_W'(655);
         setpoint_max_ff <= {SAMPLE_W{1'b1}};
         setpoint_min_ff <= '0;
         last_v_ff       <= '0;
         last_i_ff       <= '0;
         setpoint_ff     <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_STEP_SIZE:    step_size_ff    <= csr_wdata[SAMPLE_W-1:0];
               CSR_CURRENT_DB:   current_db_ff   <= csr_wdata[SAMPLE_W-1:0];
               CSR_VOLTAGE_DB:   voltage_db_ff   <= csr_wdata[SAMPLE_W-1:0];
               CSR_CONDUCT_DB:   conduct_db_ff   <= csr_wdata[CD_W-1:0];
               CSR_SETPOINT_MAX: setpoint_max_ff <= csr_wdata[SAMPLE_W-1:0];
               CSR_SETPOINT_MIN: setpoint_min_ff <= csr_wdata[SAMPLE_W-1:0];
               default: begin
               end
            endcase
         end
         if (load_beat) begin
            last_v_ff <= req_panel_voltage;
            last_i_ff <= req_panel_current;
         end
         if (update_now) begin
            setpoint_ff <= setpoint_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      mv_ff   <= mv_in;
      zv_ff   <= zv_in;
      if (load_beat) begin
         v_ff  <= req_panel_voltage;
         i_ff  <= req_panel_current;
         dv_ff <= $signed({1'b0, req_panel_voltage}) - $signed({1'b0, last_v_ff});
         di_ff <= $signed({1'b0, req_panel_current}) - $signed({1'b0, last_i_ff});
      end
      if (update_now) begin
         rsp_setpoint_ff <= setpoint_in;
         rsp_move_ff     <= mv_ff;
         rsp_zv_ff       <= zv_ff;
      end
   end

endmodule

[tb/mppt_incremental_conductance_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the incremental-conductance tracker.
// An initial block fills a queue of panel samples phase by phase. Between
// phases it waits for the tracker to drain, then rewrites the control
// registers. A clocked driver offers the queued samples in bursts. At each
// accepted request beat it runs the bench's own tracker model and queues
// the predicted response. A clocked monitor stalls the response channel on
// a changing pattern and checks every accepted response beat against the
// oldest prediction.
module mppt_incremental_conductance_test
   import mppt_ic_pkg::*;
();

   // The run ends as a failure when this many consecutive cycles pass with
   // no beat on any channel. The longest correct pause is the deliberate
   // receiver hold-off below, so this leaves ample room.
   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_OFF_LEN  = 400;
   localparam int HOLD_OFF_AT   = 300;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 106;

   typedef struct packed {
      logic [SAMPLE_W-1:0] voltage;
      logic [SAMPLE_W-1:0] current;
   } panel_sample_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] setpoint;
      move_type            move;
      logic                zero_voltage;
   } tracker_result_type;

   // Ways in which the response side withholds ready.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PATTERN
   } stall_mode_type;

   logic clock;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_panel_voltage = '0;
   logic [SAMPLE_W-1:0]    req_panel_current = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_voltage_setpoint;
   logic [1:0]             rsp_move;
   logic                   rsp_zero_voltage;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Samples waiting to be offered, and responses predicted but not yet seen.
   panel_sample_type   pending_samples[$];
   tracker_result_type predicted_results[$];

   // The bench's copy of the control registers, at their reset values.
   logic [15:0] step_size_cfg        = 16'd10;
   logic [15:0] current_deadband_cfg = 16'd5;
   logic [15:0] voltage_deadband_cfg = 16'd5;
   logic [23:0] conductance_cfg      = 24'd655;
   logic [15:0] setpoint_max_cfg     = 16'hFFFF;
   logic [15:0] setpoint_min_cfg     = 16'd0;

   // The bench's copy of the tracker's state.
   logic [SAMPLE_W-1:0] tracked_voltage  = '0;
   logic [SAMPLE_W-1:0] tracked_current  = '0;
   logic [SAMPLE_W-1:0] tracked_setpoint = '0;

   // The last sample put in the queue, which the random walks start from.
   // Queue order is acceptance order, so this is also the tracker's previous
   // sample when the new one is processed.
   longint queued_voltage = 0;
   longint queued_current = 0;

   int error_count      = 0;
   int samples_accepted = 0;
   int idle_cycles      = 0;

   // Sender state.
   int               burst_left = 0;
   int               gap_left   = 0;
   panel_sample_type next_sample;

   // Receiver state.
   stall_mode_type     stall_mode    = STALL_NONE;
   int                 mode_left     = 0;
   logic [15:0]        stall_pattern = 16'h1;
   int                 hold_off_left = 0;
   bit                 hold_off_done = 1'b0;
   tracker_result_type want;

   mppt_incremental_conductance DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_panel_voltage    (req_panel_voltage),
      .req_panel_current    (req_panel_current),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_voltage_setpoint (rsp_voltage_setpoint),
      .rsp_move             (rsp_move),
      .rsp_zero_voltage     (rsp_zero_voltage),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Advances the tracker model by one sample and returns its response.
   // The conductance test asks whether dI/dV + I/V lies outside the band
   // +/- conductance_cfg / 2^FRAC_BITS. Multiplying through by dV * V, with
   // the sign of dV folded into the sum, keeps the comparison exact.
   function automatic tracker_result_type track_sample(input logic [SAMPLE_W-1:0] volts,
                                                       input logic [SAMPLE_W-1:0] amps);
      tracker_result_type r;
      longint             dv;
      longint             di;
      longint             adv;
      longint             sum;
      longint             band;
      longint             sp;
      r.move         = MOVE_HOLD;
      r.zero_voltage = 1'b0;
      dv  = longint'(volts) - longint'(tracked_voltage);
      di  = longint'(amps) - longint'(tracked_current);
      adv = (dv < 0) ? -dv : dv;
      if (dv == 0 || adv < longint'(voltage_deadband_cfg)) begin
         // Voltage barely moved: follow the current change alone.
         if (di > longint'(current_deadband_cfg))
            r.move = MOVE_INCREASE;
         else if (di < -longint'(current_deadband_cfg))
            r.move = MOVE_DECREASE;
      end else if (volts == '0) begin
         r.zero_voltage = 1'b1;
      end else begin
         sum = di * longint'(volts) + longint'(amps) * dv;
         if (dv < 0)
            sum = -sum;
         band = (longint'(conductance_cfg) * adv * longint'(volts)) >>> FRAC_BITS;
         if (sum > band)
            r.move = MOVE_INCREASE;
         else if (-sum > band)
            r.move = MOVE_DECREASE;
      end
      sp = longint'(tracked_setpoint);
      if (r.move == MOVE_INCREASE)
         sp = sp + longint'(step_size_cfg);
      else if (r.move == MOVE_DECREASE)
         sp = sp - longint'(step_size_cfg);
      // Max is tested first; with crossed limits a value not above it gets min.
      if (sp > longint'(setpoint_max_cfg))
         sp = longint'(setpoint_max_cfg);
      else if (sp < longint'(setpoint_min_cfg))
         sp = longint'(setpoint_min_cfg);
      if (sp < 0)
         sp = 0;
      if (sp > 65535)
         sp = 65535;
      tracked_setpoint = sp[SAMPLE_W-1:0];
      tracked_voltage  = volts;
      tracked_current  = amps;
      r.setpoint       = tracked_setpoint;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] clip_sample(input longint x);
      if (x < 0)
         return '0;
      if (x > 65535)
         return '1;
      return x[SAMPLE_W-1:0];
   endfunction

   task automatic queue_sample(input longint volts, input longint amps);
      panel_sample_type s;
      s.voltage = clip_sample(volts);
      s.current = clip_sample(amps);
      pending_samples.push_back(s);
      queued_voltage = longint'(s.voltage);
      queued_current = longint'(s.current);
   endtask

   // Mostly well-formed tracking traffic: walks along a panel curve close to
   // the maximum power point, so that the conductance test falls either side
   // of its band, and small jitter that exercises both deadbands. The rest is
   // zero voltage, full-scale values and plain noise.
   task automatic queue_random_sample();
      int     kind;
      longint dv;
      longint di;
      longint denom;
      longint spread;
      longint span;
      longint v_new;
      longint i_new;
      kind  = $urandom_range(0, 99);
      v_new = longint'($urandom_range(0, 65535));
      i_new = longint'($urandom_range(0, 65535));
      if (kind < 40) begin
         dv = longint'($urandom_range(1, 3000));
         if ($urandom_range(0, 1) == 1)
            dv = -dv;
         v_new = longint'(clip_sample(queued_voltage + dv));
         if (v_new == 0)
            v_new = 1;
         dv    = v_new - queued_voltage;
         denom = v_new + dv;
         if (dv != 0 && denom > 0) begin
            // Current that would make dI/dV + I/V vanish, plus a little noise.
            di     = -(queued_current * dv) / denom;
            spread = ((dv < 0) ? -dv : dv) / 16 + 3;
            i_new  = queued_current + di + longint'($urandom_range(0, 2 * spread)) - spread;
         end
      end else if (kind < 65) begin
         span  = longint'($urandom_range(1, 40));
         v_new = queued_voltage + longint'($urandom_range(0, 2 * span)) - span;
         i_new = queued_current + longint'($urandom_range(0, 2 * span)) - span;
      end else if (kind < 75) begin
         v_new = 0;
      end else if (kind < 85) begin
         v_new = ($urandom_range(0, 1) == 1) ? 65535 : 0;
         i_new = ($urandom_range(0, 1) == 1) ? 65535 : 0;
      end
      queue_sample(v_new, i_new);
   endtask

   // One beat on the register port. The model's copy changes at the beat.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] reg_index,
                                 input logic [CSR_DATA_W-1:0]  reg_value);
      @(posedge clock);
      csr_index <= reg_index;
      csr_wdata <= reg_value;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (reg_index)
         CSR_STEP_SIZE:    step_size_cfg        = reg_value[15:0];
         CSR_CURRENT_DB:   current_deadband_cfg = reg_value[15:0];
         CSR_VOLTAGE_DB:   voltage_deadband_cfg = reg_value[15:0];
         CSR_CONDUCT_DB:   conductance_cfg      = reg_value[23:0];
         CSR_SETPOINT_MAX: setpoint_max_cfg     = reg_value[15:0];
         CSR_SETPOINT_MIN: setpoint_min_cfg     = reg_value[15:0];
         default: ;
      endcase
   endtask

   // Holds the stimulus back until every queued sample has been taken and
   // every predicted response has come out. Sampled on the falling edge so
   // that the driver and monitor have settled for the cycle.
   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   // A fresh register setting for a random phase. The 16-bit registers get
   // junk in the upper byte of the write data, which must be dropped.
   task automatic randomise_settings();
      logic [15:0] step;
      logic [15:0] cdb;
      logic [15:0] vdb;
      logic [23:0] cond;
      logic [15:0] lo;
      logic [15:0] hi;
      case ($urandom_range(0, 5))
         0:       step = 16'd0;
         1:       step = 16'hFFFF;
         default: step = 16'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 5))
         0:       cdb = 16'd0;
         1:       cdb = 16'hFFFF;
         default: cdb = 16'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 7))
         0:       vdb = 16'd0;
         1:       vdb = 16'hFFFF;
         default: vdb = 16'($urandom_range(1, 100));
      endcase
      case ($urandom_range(0, 5))
         0:       cond = 24'd0;
         1:       cond = 24'hFFFFFF;
         2:       cond = 24'($urandom);
         default: cond = 24'($urandom_range(1, 5000));
      endcase
      case ($urandom_range(0, 3))
         0: begin
            lo = 16'd0;
            hi = 16'hFFFF;
         end
         1: begin
            lo = 16'($urandom_range(0, 30000));
            hi = 16'($urandom_range(lo, 65535));
         end
         2: begin
            // Crossed limits.
            lo = 16'($urandom_range(1000, 65535));
            hi = 16'($urandom_range(0, lo - 1));
         end
         default: begin
            lo = 16'($urandom_range(0, 65535));
            hi = lo;
         end
      endcase
      write_register(CSR_STEP_SIZE,    {8'($urandom), step});
      write_register(CSR_CURRENT_DB,   {8'($urandom), cdb});
      write_register(CSR_VOLTAGE_DB,   {8'($urandom), vdb});
      write_register(CSR_CONDUCT_DB,   cond);
      write_register(CSR_SETPOINT_MAX, {8'($urandom), hi});
      write_register(CSR_SETPOINT_MIN, {8'($urandom), lo});
   endtask

   // Stimulus sequencer.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset register values.
      queue_sample(0, 0);             // no change at all: hold
      queue_sample(0, 6);             // current up past its deadband, V zero
      queue_sample(0, 11);            // current change exactly at the deadband
      queue_sample(0, 5);             // current down past its deadband
      queue_sample(0, 0);             // current down exactly at the deadband
      queue_sample(4, 0);             // voltage change inside its deadband
      queue_sample(9, 100);           // voltage change exactly at its deadband
      queue_sample(0, 100);           // conductance test due but V is zero
      queue_sample(65535, 65535);     // full scale on both inputs
      queue_sample(0, 0);
      queue_sample(65535, 0);         // sum exactly zero: hold
      queue_sample(30000, 65535);     // falling voltage, rising power
      queue_sample(31000, 1000);      // past the knee: decrease
      queue_sample(30000, 1100);      // falling voltage, decrease
      queue_sample(20000, 2000);
      queue_sample(20100, 1990);      // just inside the conductance band
      wait_until_idle();

      // Extreme step, zero deadbands and zero conductance band.
      write_register(CSR_STEP_SIZE,    24'hFFFF);
      write_register(CSR_CURRENT_DB,   24'd0);
      write_register(CSR_VOLTAGE_DB,   24'd0);
      write_register(CSR_CONDUCT_DB,   24'd0);
      write_register(CSR_SETPOINT_MAX, 24'hFFFF);
      write_register(CSR_SETPOINT_MIN, 24'd0);
      queue_sample(20100, 1991);      // increase saturates at the top
      queue_sample(20100, 1990);      // back down to zero
      queue_sample(20100, 1989);      // decrease from zero clamps at zero
      queue_sample(100, 0);
      queue_sample(200, 0);           // sum exactly zero against a zero band
      queue_sample(0, 0);             // zero voltage with a zero deadband
      wait_until_idle();

      // Crossed setpoint limits, widest deadbands and band, plus writes to
      // indexes that do not exist and must change nothing.
      write_register(CSR_SETPOINT_MAX, 24'd1000);
      write_register(CSR_SETPOINT_MIN, 24'd2000);
      write_register(CSR_STEP_SIZE,    24'd700);
      write_register(CSR_CURRENT_DB,   24'hFFFF);
      write_register(CSR_VOLTAGE_DB,   24'hFFFF);
      write_register(CSR_CONDUCT_DB,   24'hFFFFFF);
      write_register(CSR_INDEX_W'(6),  24'h000000);
      write_register('1,               24'h5A5A5A);
      queue_sample(0, 0);
      queue_sample(65535, 65535);     // only a full-scale swing leaves the deadband
      queue_sample(0, 65535);
      queue_sample(0, 0);
      queue_sample(65535, 0);

      // Random phases. The wait before each one is the point at which the
      // sender stands idle until every expected response has come back.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_until_idle();
         randomise_settings();
         repeat (PHASE_ITEMS) queue_random_sample();
      end
      wait_until_idle();
      repeat (20) @(posedge clock);

      if (predicted_results.size() != 0) begin
         $error("%0d responses never arrived", predicted_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Request driver. A beat is held until it is taken; between beats the
   // sender runs in bursts of random length separated by random gaps, some
   // of them empty so that back-to-back traffic occurs as well.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_results.push_back(track_sample(req_panel_voltage, req_panel_current));
            samples_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               next_sample = pending_samples.pop_front();
               req_valid         <= 1'b1;
               req_panel_voltage <= next_sample.voltage;
               req_panel_current <= next_sample.current;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker. Ready follows a mode that changes every
   // so often: always ready, a coin toss, or a rotating bit pattern. Once,
   // well into the random traffic, ready is withheld for a long stretch so
   // that the tracker fills up and pushes back on the request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mode_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("response with no sample outstanding: setpoint %0d, move %0d",
                      rsp_voltage_setpoint, rsp_move);
               error_count++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_voltage_setpoint !== want.setpoint) begin
                  $error("voltage_setpoint: expected %0d, got %0d",
                         want.setpoint, rsp_voltage_setpoint);
                  error_count++;
               end
               if (rsp_move !== want.move) begin
                  $error("move: expected %0d, got %0d", want.move, rsp_move);
                  error_count++;
               end
               if (rsp_zero_voltage !== want.zero_voltage) begin
                  $error("zero_voltage: expected %0d, got %0d",
                         want.zero_voltage, rsp_zero_voltage);
                  error_count++;
               end
            end
         end
         if (!hold_off_done && samples_accepted >= HOLD_OFF_AT) begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_LEN;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode    = stall_mode_type'($urandom_range(0, 2));
               mode_left     = $urandom_range(16, 128);
               stall_pattern = 16'($urandom) | 16'h1;
            end
            mode_left--;
            case (stall_mode)
               STALL_COIN:    rsp_ready <= ($urandom_range(0, 1) == 1);
               STALL_PATTERN: begin
                  rsp_ready <= stall_pattern[0];
                  stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
               end
               default:       rsp_ready <= 1'b1;
            endcase
         end
      end
   end

   // Watchdog: any beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule
